// ===== hw/rtl/rpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_pkg
// shared constants, codes and types of the reserved port range map
// ----------------------------------------------------------------------------
package rpm_pkg;

   // range table and bitmap geometry
   localparam int MAX_RANGES = 16;
   localparam int MAP_BYTES  = 8192;
   localparam int PORT_W     = 16;
   localparam int BIT_W      = 3;
   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = $clog2(MAP_BYTES);
   localparam int ENT_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);

   // operation codes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_INVALID   = 2'd3;

   typedef enum logic [8:0] {
      FSM_CLEAR  = 9'b000000001,
      FSM_IDLE   = 9'b000000010,
      FSM_QUERY  = 9'b000000100,
      FSM_SEARCH = 9'b000001000,
      FSM_WIPE   = 9'b000010000,
      FSM_SCAN   = 9'b000100000,
      FSM_READ   = 9'b001000000,
      FSM_MERGE  = 9'b010000000,
      FSM_DONE   = 9'b100000000
   } fsm_type;

endpackage

// ===== hw/rtl/rpm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/reserved_port_range_map_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reserved_port_range_map_unit
// range table of reserved ports with a one-bit-per-port reservation bitmap
//
//   channel | direction | ports
//   --------+-----------+------------------------------------------------
//   req     | in        | req_valid, req_stall, opcode, range min/max, port
//   rsp     | out       | rsp_valid, rsp_stall, status, port_reserved
//   csr     | in        | csr_wr_en, csr_wr_data (restriction enable)
//
// query: the ram is read on the req transfer, the bit is picked in QUERY, DONE loads rsp
// add or delete: table walk (SEARCH) over the entries, then a bitmap rebuild:
// a wipe of all MAP_BYTES bytes, a scan of the entries, a read and merge per byte a live range spans
// after reset a clearing pass over all MAP_BYTES bytes runs before req is taken
// one item at a time: req_stall is high whenever the sequencer is not idle
// a finished result sits in the rsp register, a new req may be taken then
// ----------------------------------------------------------------------------
module reserved_port_range_map_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_opcode,
   input  logic [rpm_pkg::PORT_W-1:0] req_range_min,
   input  logic [rpm_pkg::PORT_W-1:0] req_range_max,
   input  logic [rpm_pkg::PORT_W-1:0] req_query_port,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_port_reserved,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data
);
   import rpm_pkg::*;

   // sequencer and counters
   fsm_type                   state_ff, state_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic [CNT_W-1:0]          ent_ff, ent_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   // range table
   logic [MAX_RANGES-1:0]     live_ff, live_in;
   logic [PORT_W-1:0]         low_ff  [MAX_RANGES];
   logic [PORT_W-1:0]         low_in  [MAX_RANGES];
   logic [PORT_W-1:0]         high_ff [MAX_RANGES];
   logic [PORT_W-1:0]         high_in [MAX_RANGES];

   // latched request and pending result
   logic [1:0]                op_ff, op_in;
   logic [PORT_W-1:0]         lo_ff, lo_in;
   logic [PORT_W-1:0]         hi_ff, hi_in;
   logic [BIT_W-1:0]          qbit_ff, qbit_in;
   logic [1:0]                st_ff, st_in;
   logic                      res_ff, res_in;

   // output register and csr
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic                      rsp_reserved_ff, rsp_reserved_in;
   logic                      enable_ff, enable_in;

   // bitmap ram
   logic                      ram_wr_en;
   logic [BYTE_W-1:0]         ram_wr_data;
   logic [ADDR_W-1:0]         ram_rd_addr;
   logic [BYTE_W-1:0]         ram_rd_data;

   // helpers
   logic [ENT_W-1:0]          cur_idx;
   logic [ENT_W-1:0]          app_idx;
   logic [PORT_W-1:0]         cur_low;
   logic [PORT_W-1:0]         cur_high;
   logic                      addr_last;
   logic                      ent_past;
   logic                      hit;
   logic                      at_hi_byte;
   logic [BYTE_W-1:0]         lo_mask;
   logic [BYTE_W-1:0]         hi_mask;
   logic                      accept;
   logic                      rsp_free;

   assign cur_idx   = ent_ff[ENT_W-1:0];
   assign app_idx   = count_ff[ENT_W-1:0];
   assign cur_low   = low_ff[cur_idx];
   assign cur_high  = high_ff[cur_idx];
   assign addr_last = (addr_ff == ADDR_W'(MAP_BYTES - 1));
   assign ent_past  = (ent_ff >= count_ff);
   assign hit       = (cur_low == lo_ff) && (cur_high == hi_ff);

   // byte mask of the current entry over the byte at addr_ff
   assign at_hi_byte = (addr_ff == cur_high[PORT_W-1:BIT_W]);
   assign lo_mask    = (addr_ff == cur_low[PORT_W-1:BIT_W]) ?
                       (BYTE_W'(8'hFF) << cur_low[BIT_W-1:0]) : BYTE_W'(8'hFF);
   assign hi_mask    = at_hi_byte ?
                       (BYTE_W'(8'hFF) >> (BIT_W'(7) - cur_high[BIT_W-1:0])) :
                       BYTE_W'(8'hFF);

   assign accept    = req_valid && (state_ff == FSM_IDLE);
   assign rsp_free  = !(rsp_valid_ff && rsp_stall);

   // query reads straight off the request, every other access off addr_ff
   assign ram_rd_addr = (state_ff == FSM_IDLE) ? req_query_port[PORT_W-1:BIT_W] : addr_ff;

   rpm_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAP_BYTES)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in        = state_ff;
      addr_in         = addr_ff;
      ent_in          = ent_ff;
      count_in        = count_ff;
      live_in         = live_ff;
      low_in          = low_ff;
      high_in         = high_ff;
      op_in           = op_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      qbit_in         = qbit_ff;
      st_in           = st_ff;
      res_in          = res_ff;
      ram_wr_en       = 1'b0;
      ram_wr_data     = '0;
      enable_in       = csr_wr_en ? csr_wr_data : enable_ff;

      // output register drains on a transfer
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_reserved_in = rsp_reserved_ff;

      unique case (state_ff)
         FSM_CLEAR: begin
            // post-reset sweep of the bitmap
            ram_wr_en = 1'b1;
            addr_in   = addr_ff + 1'b1;
            if (addr_last) begin
               state_in = FSM_IDLE;
            end
         end

         FSM_IDLE: begin
            if (accept) begin
               op_in   = req_opcode;
               lo_in   = req_range_min;
               hi_in   = req_range_max;
               qbit_in = req_query_port[BIT_W-1:0];
               res_in  = 1'b0;
               st_in   = ST_OK;
               ent_in  = '0;
               if (req_opcode == OP_QUERY) begin
                  state_in = FSM_QUERY;
               end else if (req_opcode == OP_ADD || req_opcode == OP_DELETE) begin
                  if (req_range_min > req_range_max) begin
                     st_in    = ST_INVALID;
                     state_in = FSM_DONE;
                  end else begin
                     state_in = FSM_SEARCH;
                  end
               end else begin
                  // unused opcode: plain ok
                  state_in = FSM_DONE;
               end
            end
         end

         FSM_QUERY: begin
            res_in   = enable_ff && ram_rd_data[qbit_ff];
            state_in = FSM_DONE;
         end

         FSM_SEARCH: begin
            addr_in = '0;
            if (ent_past) begin
               // no exact match in the table
               if (op_ff == OP_DELETE) begin
                  st_in    = ST_NOT_FOUND;
                  state_in = FSM_DONE;
               end else if (count_ff < CNT_W'(MAX_RANGES)) begin
                  low_in[app_idx]  = lo_ff;
                  high_in[app_idx] = hi_ff;
                  live_in[app_idx] = 1'b1;
                  count_in         = count_ff + 1'b1;
                  st_in            = ST_OK;
                  state_in         = FSM_WIPE;
               end else begin
                  st_in    = ST_FULL;
                  state_in = FSM_DONE;
               end
            end else if (hit) begin
               live_in[cur_idx] = (op_ff != OP_DELETE);
               st_in            = ST_OK;
               state_in         = FSM_WIPE;
            end else begin
               ent_in = ent_ff + 1'b1;
            end
         end

         FSM_WIPE: begin
            ram_wr_en = 1'b1;
            addr_in   = addr_ff + 1'b1;
            if (addr_last) begin
               ent_in   = '0;
               state_in = FSM_SCAN;
            end
         end

         FSM_SCAN: begin
            if (ent_past) begin
               state_in = FSM_DONE;
            end else if (live_ff[cur_idx]) begin
               addr_in  = cur_low[PORT_W-1:BIT_W];
               state_in = FSM_READ;
            end else begin
               ent_in = ent_ff + 1'b1;
            end
         end

         FSM_READ: begin
            state_in = FSM_MERGE;
         end

         FSM_MERGE: begin
            // read-modify-write of one bitmap byte
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data | (lo_mask & hi_mask);
            if (at_hi_byte) begin
               ent_in   = ent_ff + 1'b1;
               state_in = FSM_SCAN;
            end else begin
               addr_in  = addr_ff + 1'b1;
               state_in = FSM_READ;
            end
         end

         FSM_DONE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = st_ff;
               rsp_reserved_in = res_ff;
               state_in        = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         addr_ff      <= '0;
         ent_ff       <= '0;
         count_ff     <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         ent_ff       <= ent_in;
         count_ff     <= count_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         enable_ff    <= enable_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      low_ff          <= low_in;
      high_ff         <= high_in;
      op_ff           <= op_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      qbit_ff         <= qbit_in;
      st_ff           <= st_in;
      res_ff          <= res_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_reserved_ff <= rsp_reserved_in;
   end

   assign req_stall         = (state_ff != FSM_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_port_reserved = rsp_reserved_ff;

endmodule

// ===== hw/rtl/rpm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_checker
// port-level checks of the reserved port range map, bound to the top level
// ----------------------------------------------------------------------------
module rpm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [1:0]                 rsp_status,
   input logic                       rsp_port_reserved
);
   import rpm_pkg::*;

   // nothing left in the output register after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one item at a time: a transfer closes the request side next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous item in flight");

   // a reserved port is only ever reported with ok status
   a_reserved_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_port_reserved) |-> (rsp_status == ST_OK))
      else $error("reserved flag with error status");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_port_reserved)))
      else $error("stalled result changed");

endmodule

bind reserved_port_range_map_unit rpm_checker u_rpm_checker (.*);
